// ===== src/tpid_pkg.sv =====
// shared types, constants and table functions for the terrain patch idct decoder
package tpid_pkg;

   localparam int PATCH_EDGE_DEF = 16;
   localparam int COEF_W         = 18;
   localparam int DEQ_W          = 25;
   localparam int WORK_W         = 40;
   localparam int ACC_W          = 64;
   localparam int Z_W            = 50;
   localparam int DV_W           = 56;
   localparam int DIV_RADIX      = 8;
   localparam int DIV_CYCLES     = DV_W / DIV_RADIX;
   localparam int HEIGHT_W       = 24;

   localparam logic signed [15:0] DC_WEIGHT = 16'sd23170;
   localparam logic [63:0]        PI_Q30    = 64'd3373259426;
   localparam logic signed [63:0] H_MAX     = 64'sd8388607;
   localparam logic signed [63:0] H_MIN     = -64'sd8388608;

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic [3:0]               quant_code;
      logic [15:0]              height_range;
      logic signed [23:0]       dc_offset;
   } req_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height_a;
      logic signed [HEIGHT_W-1:0] height_b;
      logic signed [HEIGHT_W-1:0] height_c;
      logic signed [HEIGHT_W-1:0] height_d;
      logic [3:0]                 row_index;
      logic [1:0]                 column_group;
      logic                       last;
   } rsp_type;

   // unsigned quotient by shift and subtract
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // cosine magnitude in q1.15 from an angle in q30, taylor series
   function automatic logic [15:0] cos_mag(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        mag;
      logic signed [63:0] sum;
      logic [63:0]        q;
      logic [63:0]        den;
      x2  = (x * x + (64'd1 << 29)) >> 30;
      mag = 64'd1 << 30;
      sum = 64'sd1 <<< 30;
      for (int i = 1; i <= 12; i++) begin
         den = 64'((2 * i - 1) * (2 * i));
         mag = udiv64((mag * x2) >> 30, den);
         if (i % 2 == 1) begin
            sum = sum - $signed(mag);
         end else begin
            sum = sum + $signed(mag);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      q = 64'((sum + 64'sd16384) >>> 15);
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[15:0];
   endfunction

   // number of trailing zero bits of the patch edge
   function automatic int trail_zeros(input int e);
      int  t;
      int  v;
      logic done;
      t    = 0;
      v    = e;
      done = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!done && v % 2 == 0) begin
            v = v / 2;
            t = t + 1;
         end else begin
            done = 1'b1;
         end
      end
      return t;
   endfunction

endpackage

// ===== src/tpid_ram.sv =====
// generic single write port ram with registered read
module tpid_ram #(
   parameter int WIDTH = tpid_pkg::WORK_W,
   parameter int DEPTH = tpid_pkg::PATCH_EDGE_DEF * tpid_pkg::PATCH_EDGE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/terrain_patch_idct_decoder.sv =====
// terrain patch decoder: zigzag reorder, dequantise, 2-d idct and height rescale
//
// req channel: PATCH_EDGE*PATCH_EDGE beats of one patch, coefficients in zigzag
// order; the header fields of the final beat of a patch are the ones used.
// req_stall is low only while a patch is being loaded, one beat per cycle.
// rsp channel: after the final beat the patch is transformed and one beat of
// four heights per group of four columns is sent, row by row, last set on the
// final beat of the patch; columns past the edge read as zero.
// all multiplications go through one shared multiplier, fed from the two rams
// during the transform, one product per cycle while the mac state runs: a
// column pass and a row pass of PATCH_EDGE^3 products each, then one product
// per height for the rescale. an edge that is not a power of two adds a
// division per height.
// while the receiver stalls, the held beat stays on rsp and work pauses.
// reset (synchronous, active high) empties the block and starts a new patch;
// the rams need no clearing.
module terrain_patch_idct_decoder #(
   parameter int PATCH_EDGE = tpid_pkg::PATCH_EDGE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tpid_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tpid_pkg::rsp_type rsp_data
);

   localparam int CELLS = PATCH_EDGE * PATCH_EDGE;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = $clog2(PATCH_EDGE);
   localparam int KN    = 4 * PATCH_EDGE;
   localparam int KW    = $clog2(KN);
   localparam int FW    = $clog2(KN);
   localparam int SH_T  = tpid_pkg::trail_zeros(PATCH_EDGE);
   localparam int DIV_M = PATCH_EDGE >> SH_T;
   localparam int RND_K = 32769 * PATCH_EDGE;
   localparam int DCW   = $clog2(tpid_pkg::DIV_CYCLES);
   localparam int DQW   = tpid_pkg::DEQ_W;
   localparam int WKW   = tpid_pkg::WORK_W;
   localparam int ZW    = tpid_pkg::Z_W;
   localparam int DVW   = tpid_pkg::DV_W;

   typedef enum logic [2:0] {
      ST_LOAD, ST_MAC, ST_DRAIN, ST_POST, ST_DIV, ST_MUL, ST_HGT, ST_EMIT
   } state_type;

   // cosine table indexed by (2n+1)u modulo 4*edge
   logic signed [15:0] cos_rom [KN];

   for (genvar gk = 0; gk < KN; gk++) begin : g_cos
      localparam int KM           = (gk > 2 * PATCH_EDGE) ? KN - gk : gk;
      localparam bit NEG          = KM > PATCH_EDGE;
      localparam int KR           = NEG ? 2 * PATCH_EDGE - KM : KM;
      localparam logic [63:0] XQ  =
         (64'(KR) * tpid_pkg::PI_Q30 + 64'(PATCH_EDGE)) / 64'(2 * PATCH_EDGE);
      localparam logic signed [15:0] MAGS = $signed(tpid_pkg::cos_mag(XQ));
      assign cos_rom[gk] = NEG ? -MAGS : MAGS;
   end

   state_type state_ff, state_in;
   logic [AW-1:0] lc_ff, lc_in;
   logic [IW-1:0] zr_ff, zr_in, zc_ff, zc_in;
   logic zdiag_ff, zdiag_in, zright_ff, zright_in;
   logic [3:0] held_quant_ff, held_quant_in;
   logic [15:0] held_range_ff, held_range_in;
   logic signed [23:0] held_offset_ff, held_offset_in;
   logic row_ff, row_in;
   logic [IW-1:0] o_ff, o_in, n_ff, n_in, iu_ff, iu_in;
   logic [KW-1:0] k_ff, k_in;
   logic p1_vld_ff, p1_vld_in, p1_first_ff, p1_first_in, p1_last_ff, p1_last_in;
   logic p2_vld_ff, p2_vld_in, p2_first_ff, p2_first_in, p2_last_ff, p2_last_in;
   logic acc_done_ff, acc_done_in;
   logic signed [15:0] cosw_ff, cosw_in;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [DVW-1:0] dv_ff, dv_in;
   logic [4:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [DCW-1:0] dc_ff, dc_in;
   logic signed [23:0] grp_ff [4];
   logic signed [23:0] grp_in [4];
   logic rsp_valid_ff, rsp_valid_in;
   tpid_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic coef_we, work_we;
   logic [AW-1:0] coef_wa, coef_ra, work_wa, work_ra;
   logic signed [DQW-1:0] deq, coef_rd;
   logic signed [WKW-1:0] work_wd, work_rd;
   logic [FW-1:0] fac;
   logic signed [ZW-1:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [ZW+16:0] prod_full;
   logic signed [23:0] hgt;

   // dequantise on the way in
   assign fac     = FW'({FW'(zr_ff) + FW'(zc_ff), 1'b1});
   assign deq     = $signed({{(DQW - tpid_pkg::COEF_W){req_data.coefficient[17]}},
                             req_data.coefficient})
                    * $signed({{(DQW - FW){1'b0}}, fac});
   assign coef_wa = AW'(zr_ff) * AW'(PATCH_EDGE) + AW'(zc_ff);
   assign coef_ra = AW'(iu_ff) * AW'(PATCH_EDGE) + AW'(o_ff);
   assign work_wa = AW'(n_ff) * AW'(PATCH_EDGE) + AW'(o_ff);
   assign work_ra = AW'(o_ff) * AW'(PATCH_EDGE) + AW'(iu_ff);
   assign work_wd = WKW'((acc_ff + 64'sd64) >>> 7);

   tpid_ram #(.WIDTH(DQW), .DEPTH(CELLS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_wa),
      .wr_data (deq),
      .rd_addr (coef_ra),
      .rd_data (coef_rd)
   );

   tpid_ram #(.WIDTH(WKW), .DEPTH(CELLS)) u_work_ram (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_wa),
      .wr_data (work_wd),
      .rd_addr (work_ra),
      .rd_data (work_rd)
   );

   // shared multiplier
   always_comb begin
      if (state_ff == ST_MUL) begin
         mul_a = z_ff;
         mul_b = $signed({1'b0, held_range_ff});
      end else begin
         mul_a = row_ff ? $signed({{(ZW - WKW){work_rd[WKW-1]}}, work_rd})
                        : $signed({{(ZW - DQW){coef_rd[DQW-1]}}, coef_rd});
         mul_b = $signed({cosw_ff[15], cosw_ff});
      end
   end
   assign prod_full = mul_a * mul_b;
   assign prod_in   = prod_full[63:0];

   // rescale of one height
   always_comb begin
      logic [4:0]         shamt;
      logic signed [63:0] rbias, rsh, hsum;
      shamt = 5'(held_quant_ff) + 5'd2;
      rbias = 64'sd1 <<< (shamt - 5'd1);
      rsh   = (prod_ff + rbias) >>> shamt;
      hsum  = rsh + $signed({41'b0, held_range_ff, 7'b0})
              + $signed({{40{held_offset_ff[23]}}, held_offset_ff});
      if (hsum > tpid_pkg::H_MAX) begin
         hgt = tpid_pkg::H_MAX[23:0];
      end else if (hsum < tpid_pkg::H_MIN) begin
         hgt = tpid_pkg::H_MIN[23:0];
      end else begin
         hgt = hsum[23:0];
      end
   end

   always_comb begin
      logic               row_end, pass_end, emit;
      logic [KW:0]        ksum;
      logic signed [65:0] nsum;
      logic signed [ZW-1:0] xs;
      logic [ZW-1:0]      umag, q;
      logic [DVW-1:0]     dv;
      logic [5:0]         dt;
      logic [4:0]         rm;

      state_in       = state_ff;
      lc_in          = lc_ff;
      zr_in          = zr_ff;
      zc_in          = zc_ff;
      zdiag_in       = zdiag_ff;
      zright_in      = zright_ff;
      held_quant_in  = held_quant_ff;
      held_range_in  = held_range_ff;
      held_offset_in = held_offset_ff;
      row_in         = row_ff;
      o_in           = o_ff;
      n_in           = n_ff;
      iu_in          = iu_ff;
      k_in           = k_ff;
      cosw_in        = cosw_ff;
      z_in           = z_ff;
      dv_in          = dv_ff;
      rem_in         = rem_ff;
      neg_in         = neg_ff;
      dc_in          = dc_ff;
      grp_in         = grp_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff;
      coef_we        = 1'b0;
      work_we        = 1'b0;

      row_end  = n_ff == IW'(PATCH_EDGE - 1);
      pass_end = row_end && o_ff == IW'(PATCH_EDGE - 1);
      emit     = n_ff[1:0] == 2'd3 || row_end;
      ksum     = (KW + 1)'(k_ff) + (KW + 1)'({n_ff, 1'b1});
      nsum     = ($signed({{2{acc_ff[63]}}, acc_ff}) <<< 2) + 66'(RND_K);
      xs       = $signed(nsum[65:16]) >>> SH_T;
      umag     = xs[ZW-1] ? ZW'(-xs + ZW'(DIV_M - 1)) : xs;
      dv       = dv_ff;
      rm       = rem_ff;
      dt       = 6'd0;
      for (int i = 0; i < tpid_pkg::DIV_RADIX; i++) begin
         dt = {rm, dv[DVW-1]};
         dv = {dv[DVW-2:0], 1'b0};
         if (dt >= 6'(DIV_M)) begin
            dt    = dt - 6'(DIV_M);
            dv[0] = 1'b1;
         end
         rm = dt[4:0];
      end
      q = dv[ZW-1:0];

      // mac pipeline
      p1_vld_in   = 1'b0;
      p1_first_in = 1'b0;
      p1_last_in  = 1'b0;
      p2_vld_in   = p1_vld_ff;
      p2_first_in = p1_first_ff;
      p2_last_in  = p1_last_ff;
      acc_done_in = p2_vld_ff && p2_last_ff;
      acc_in      = acc_ff;
      if (p2_vld_ff) begin
         acc_in = p2_first_ff ? prod_ff : acc_ff + prod_ff;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               coef_we        = 1'b1;
               held_quant_in  = req_data.quant_code;
               held_range_in  = req_data.height_range;
               held_offset_in = req_data.dc_offset;
               lc_in          = lc_ff + AW'(1);
               // zigzag walk to the next raster place
               if (!zdiag_ff) begin
                  if (zright_ff) begin
                     if (zc_ff < IW'(PATCH_EDGE - 1)) zc_in = zc_ff + IW'(1);
                     else zr_in = zr_ff + IW'(1);
                     zright_in = 1'b0;
                  end else begin
                     if (zr_ff < IW'(PATCH_EDGE - 1)) zr_in = zr_ff + IW'(1);
                     else zc_in = zc_ff + IW'(1);
                     zright_in = 1'b1;
                  end
                  zdiag_in = 1'b1;
               end else if (zright_ff) begin
                  zc_in = zc_ff + IW'(1);
                  zr_in = zr_ff - IW'(1);
                  if (zc_in == IW'(PATCH_EDGE - 1) || zr_in == '0) zdiag_in = 1'b0;
               end else begin
                  zc_in = zc_ff - IW'(1);
                  zr_in = zr_ff + IW'(1);
                  if (zr_in == IW'(PATCH_EDGE - 1) || zc_in == '0) zdiag_in = 1'b0;
               end
               if (lc_ff == AW'(CELLS - 1)) begin
                  lc_in     = '0;
                  zr_in     = '0;
                  zc_in     = '0;
                  zdiag_in  = 1'b0;
                  zright_in = 1'b1;
                  row_in    = 1'b0;
                  o_in      = '0;
                  n_in      = '0;
                  iu_in     = '0;
                  k_in      = '0;
                  state_in  = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            p1_vld_in   = 1'b1;
            p1_first_in = iu_ff == '0;
            p1_last_in  = iu_ff == IW'(PATCH_EDGE - 1);
            cosw_in     = (iu_ff == '0) ? tpid_pkg::DC_WEIGHT : cos_rom[k_ff];
            k_in        = (ksum >= (KW + 1)'(KN)) ? KW'(ksum - (KW + 1)'(KN)) : KW'(ksum);
            iu_in       = iu_ff + IW'(1);
            if (iu_ff == IW'(PATCH_EDGE - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (acc_done_ff) begin
               if (!row_ff) begin
                  work_we  = 1'b1;
                  iu_in    = '0;
                  k_in     = '0;
                  state_in = ST_MAC;
                  if (row_end) begin
                     n_in = '0;
                     o_in = pass_end ? '0 : o_ff + IW'(1);
                     if (pass_end) row_in = 1'b1;
                  end else begin
                     n_in = n_ff + IW'(1);
                  end
               end else begin
                  state_in = ST_POST;
               end
            end
         end
         ST_POST: begin
            if (DIV_M == 1) begin
               z_in     = xs;
               state_in = ST_MUL;
            end else begin
               neg_in   = xs[ZW-1];
               dv_in    = DVW'(umag);
               rem_in   = '0;
               dc_in    = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dv_in  = dv;
            rem_in = rm;
            dc_in  = dc_ff + DCW'(1);
            if (dc_ff == DCW'(tpid_pkg::DIV_CYCLES - 1)) begin
               z_in     = neg_ff ? -$signed(q) : $signed(q);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_HGT;
         end
         ST_HGT: begin
            grp_in[n_ff[1:0]] = hgt;
            if (emit) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.height_a     = grp_in[0];
               rsp_data_in.height_b     = grp_in[1];
               rsp_data_in.height_c     = grp_in[2];
               rsp_data_in.height_d     = grp_in[3];
               rsp_data_in.row_index    = 4'(o_ff);
               rsp_data_in.column_group = 2'(n_ff >> 2);
               rsp_data_in.last         = pass_end;
               state_in                 = ST_EMIT;
            end else begin
               n_in     = n_ff + IW'(1);
               iu_in    = '0;
               k_in     = '0;
               state_in = ST_MAC;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               for (int i = 0; i < 4; i++) grp_in[i] = '0;
               iu_in = '0;
               k_in  = '0;
               if (row_end) begin
                  n_in = '0;
                  o_in = pass_end ? '0 : o_ff + IW'(1);
               end else begin
                  n_in = n_ff + IW'(1);
               end
               if (pass_end) begin
                  row_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cosw_ff     <= cosw_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      z_ff        <= z_in;
      dv_ff       <= dv_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      grp_ff      <= grp_in;
      rsp_data_ff <= rsp_data_in;
      p1_first_ff <= p1_first_in;
      p1_last_ff  <= p1_last_in;
      p2_first_ff <= p2_first_in;
      p2_last_ff  <= p2_last_in;
      if (reset) begin
         state_ff       <= ST_LOAD;
         lc_ff          <= '0;
         zr_ff          <= '0;
         zc_ff          <= '0;
         zdiag_ff       <= 1'b0;
         zright_ff      <= 1'b1;
         held_quant_ff  <= '0;
         held_range_ff  <= '0;
         held_offset_ff <= '0;
         row_ff         <= 1'b0;
         o_ff           <= '0;
         n_ff           <= '0;
         iu_ff          <= '0;
         k_ff           <= '0;
         dc_ff          <= '0;
         p1_vld_ff      <= 1'b0;
         p2_vld_ff      <= 1'b0;
         acc_done_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lc_ff          <= lc_in;
         zr_ff          <= zr_in;
         zc_ff          <= zc_in;
         zdiag_ff       <= zdiag_in;
         zright_ff      <= zright_in;
         held_quant_ff  <= held_quant_in;
         held_range_ff  <= held_range_in;
         held_offset_ff <= held_offset_in;
         row_ff         <= row_in;
         o_ff           <= o_in;
         n_ff           <= n_in;
         iu_ff          <= iu_in;
         k_ff           <= k_in;
         dc_ff          <= dc_in;
         p1_vld_ff      <= p1_vld_in;
         p2_vld_ff      <= p2_vld_in;
         acc_done_ff    <= acc_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_LOAD;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_load_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result beat pending while loading");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !req_stall)
      else $error("not ready for a new patch after the final beat");

   a_acc_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      acc_done_ff |-> state_ff == ST_DRAIN)
      else $error("sum finished outside drain");

endmodule
